// ===== rtl/pnd_pkg.sv =====
// pnd_pkg: shared types and constants of the packed number decoder
// no dependencies; imported by pnd_front, pnd_back and the top level of the decoder
`timescale 1ns / 1ps
`default_nettype none

package pnd_pkg;

  localparam int unsigned VALUE_W = 32;

  localparam logic [3:0] DYN_F_MAX       = 4'd13;
  localparam logic [3:0] CODE_REPEAT     = 4'd14;
  localparam logic [3:0] CODE_REPEAT_ONE = 4'd15;
  localparam logic [3:0] NYBBLE_MASK     = 4'hf;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_NYBBLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    RK_RUN    = 2'd0,
    RK_REPEAT = 2'd1,
    RK_ERROR  = 2'd2
  } rk_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SECOND = 2'd1,
    PH_ZEROS  = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  // classified input word
  typedef struct packed {
    kind_e      kind;
    logic [3:0] nybble;
    logic       nyb_zero;
    logic       nyb_escape;
    logic [3:0] dyn_f;
    logic       init_black;
  } cmd_t;

  // result word
  typedef struct packed {
    rk_e                kind;
    logic [VALUE_W-1:0] value;
    logic               black;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/pnd_fifo.sv =====
// pnd_fifo: small register queue used between the decoder parts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pnd_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count missed a write");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/pnd_front.sv =====
// pnd_front: accepts input words, classifies them and queues them
// depends on pnd_pkg and pnd_fifo
`timescale 1ns / 1ps
`default_nettype none

module pnd_front
  import pnd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       kind_i,
  input  wire logic [3:0] nybble_i,
  input  wire logic [3:0] dyn_f_i,
  input  wire logic       init_black_i,
  output cmd_t            cmd_o,
  output logic            cmd_valid_o,
  input  wire logic       cmd_take_i
);

  cmd_t cmd_in;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.kind        = kind_e'(kind_i);
    cmd_in.nybble      = nybble_i & NYBBLE_MASK;
    cmd_in.nyb_zero    = (nybble_i == 4'd0);
    cmd_in.nyb_escape  = (nybble_i == CODE_REPEAT) || (nybble_i == CODE_REPEAT_ONE);
    cmd_in.dyn_f       = (dyn_f_i > DYN_F_MAX) ? DYN_F_MAX : dyn_f_i;
    cmd_in.init_black  = init_black_i;
  end

  pnd_fifo #(
    .DEPTH(DEPTH),
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_take_i),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = ~q_empty;

endmodule

`default_nettype wire

// ===== rtl/pnd_back.sv =====
// pnd_back: packed number decoder state machine, one word per cycle while the result queue has room
// depends on pnd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pnd_back
  import pnd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = 7
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_valid_i,
  output logic       cmd_take_o,
  input  wire logic  res_full_i,
  output logic       res_push_o,
  output res_t       res_o
);

  // long count offset: value = digits + 13*16 - 15 - 15*dyn_f
  localparam logic [8:0] LONG_BIAS = 9'd193;

  phase_e             phase_q, phase_d;
  logic [2:0]         zp_q, zp_d;
  logic [3:0]         dl_q, dl_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [3:0]         lead_q, lead_d;
  logic               rep_q, rep_d;
  logic               col_q, col_d;
  logic [3:0]         dyn_q, dyn_d;

  logic               fire;
  logic               emit, err, rep_eff, clear;
  logic [VALUE_W-1:0] acc_next;
  logic [VALUE_W+1:0] long_sum;
  logic [8:0]         second_val;
  logic [VALUE_W-1:0] count_val;
  logic [3:0]         n;

  assign fire       = cmd_valid_i & ~res_full_i;
  assign cmd_take_o = fire;
  assign n          = cmd_i.nybble;
  assign acc_next   = {acc_q[VALUE_W-5:0], n};
  assign long_sum   = (VALUE_W + 2)'(acc_next) + (VALUE_W + 2)'(LONG_BIAS)
                    - (VALUE_W + 2)'({dyn_q, 4'b0000}) + (VALUE_W + 2)'(dyn_q);
  assign second_val = 9'({lead_q - dyn_q - 4'd1, 4'b0000}) + 9'(n) + 9'(dyn_q) + 9'd1;

  // word classification and data path
  always_comb begin
    emit      = 1'b0;
    err       = 1'b0;
    rep_eff   = rep_q;
    count_val = '0;
    zp_d      = zp_q;
    dl_d      = dl_q;
    acc_d     = acc_q;
    lead_d    = lead_q;
    rep_d     = rep_q;
    col_d     = col_q;
    dyn_d     = dyn_q;
    clear     = 1'b0;
    if (fire) begin
      if (cmd_i.kind == KIND_START) begin
        clear = 1'b1;
        dyn_d = cmd_i.dyn_f;
        col_d = cmd_i.init_black;
      end else begin
        unique case (phase_q)
          PH_SECOND: begin
            emit      = 1'b1;
            count_val = VALUE_W'(second_val);
          end
          PH_ZEROS: begin
            if (cmd_i.nyb_zero) begin
              if (zp_q >= 3'(MAX_PREFIX)) begin
                err = 1'b1;
              end else begin
                zp_d = zp_q + 3'd1;
              end
            end else begin
              acc_d = VALUE_W'(n);
              dl_d  = {1'b0, zp_q};
            end
          end
          PH_DIGITS: begin
            acc_d = acc_next;
            if (dl_q != 4'd0) begin
              dl_d = dl_q - 4'd1;
            end
            if (dl_q <= 4'd1) begin
              emit      = 1'b1;
              count_val = (long_sum[VALUE_W+1:VALUE_W] != 2'b00) ? '1
                                                                 : long_sum[VALUE_W-1:0];
            end
          end
          PH_IDLE: begin
            if (cmd_i.nyb_zero) begin
              zp_d = 3'd1;
            end else if (n <= dyn_q) begin
              emit      = 1'b1;
              count_val = VALUE_W'(n);
            end else if (!cmd_i.nyb_escape) begin
              lead_d = n;
            end else if (rep_q) begin
              err = 1'b1;
            end else if (n == CODE_REPEAT) begin
              rep_d = 1'b1;
            end else begin
              rep_eff   = 1'b1;
              emit      = 1'b1;
              count_val = VALUE_W'(1);
            end
          end
          default: ;
        endcase
      end
    end

    res_push_o  = fire & (emit | err);
    res_o.kind  = RK_RUN;
    res_o.value = '0;
    res_o.black = 1'b0;
    if (err) begin
      res_o.kind = RK_ERROR;
      clear      = 1'b1;
    end else if (emit) begin
      res_o.value = count_val;
      clear       = 1'b1;
      if (rep_eff) begin
        res_o.kind = RK_REPEAT;
      end else begin
        res_o.black = col_q;
        col_d       = ~col_q;
      end
    end

    if (clear) begin
      zp_d   = '0;
      dl_d   = '0;
      acc_d  = '0;
      lead_d = '0;
      rep_d  = 1'b0;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      if (cmd_i.kind == KIND_START || emit || err) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (cmd_i.nyb_zero) begin
              phase_d = PH_ZEROS;
            end else if (!cmd_i.nyb_escape && n > dyn_q) begin
              phase_d = PH_SECOND;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_ZEROS: begin
            phase_d = cmd_i.nyb_zero ? PH_ZEROS : PH_DIGITS;
          end
          PH_DIGITS: phase_d = PH_DIGITS;
          PH_SECOND: phase_d = PH_IDLE;
          default:   phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      zp_q    <= '0;
      dl_q    <= '0;
      acc_q   <= '0;
      lead_q  <= '0;
      rep_q   <= 1'b0;
      col_q   <= 1'b0;
      dyn_q   <= '0;
    end else begin
      phase_q <= phase_d;
      zp_q    <= zp_d;
      dl_q    <= dl_d;
      acc_q   <= acc_d;
      lead_q  <= lead_d;
      rep_q   <= rep_d;
      col_q   <= col_d;
      dyn_q   <= dyn_d;
    end
  end

  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIGITS) |-> (dl_q != 4'd0))
    else $error("digit phase with no digits left");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == RK_ERROR) |-> (res_o.value == '0 && !res_o.black))
    else $error("error word carries data");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.kind == KIND_START) |=> (phase_q == PH_IDLE && !rep_q))
    else $error("start did not clear the number");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full_i |-> !res_push_o)
    else $error("result pushed into full queue");

  a_run_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == RK_RUN) |=> (col_q != $past(col_q)))
    else $error("colour did not toggle after a run");

endmodule

`default_nettype wire

// ===== rtl/pk_packed_number_decoder_core.sv =====
// pk_packed_number_decoder_core: top level of the packed run count decoder
// depends on pnd_pkg, pnd_front, pnd_back and pnd_fifo
//
//   channel   direction  handshake     word
//   input     in         push / full   kind_i, nybble_i, dyn_f_i, init_black_i
//   result    out        pop / empty   result_kind_o, value_o, black_o
//
// one word per cycle while the result queue has room; pnd_back holds the state loop
// input words are registered in the input queue, result words in the result queue
// reset clears the queues and the decoder state (colour white, dyn_f zero)
// a full result queue stalls the decoder; the input queue then fills and raises full
`timescale 1ns / 1ps
`default_nettype none

module pk_packed_number_decoder_core
  import pnd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX  = 7,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               kind_i,
  input  wire logic [3:0]         nybble_i,
  input  wire logic [3:0]         dyn_f_i,
  input  wire logic               init_black_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              result_kind_o,
  output logic [VALUE_W-1:0]      value_o,
  output logic                    black_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  pnd_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .nybble_i     (nybble_i),
    .dyn_f_i      (dyn_f_i),
    .init_black_i (init_black_i),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_take_i   (cmd_take)
  );

  pnd_back #(
    .MAX_PREFIX(MAX_PREFIX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_take_o (cmd_take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  pnd_fifo #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_out       = res_t'(res_rdata);
  assign result_kind_o = res_out.kind;
  assign value_o       = res_out.value;
  assign black_o       = res_out.black;

endmodule

`default_nettype wire

// ===== verif/pnd_checker.sv =====
// pnd_checker: predicts and checks the result words of the packed number decoder
// depends on pnd_pkg; watches the push / full and pop / empty channels of the core
`timescale 1ns / 1ps

module pnd_checker
  import pnd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = 7
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  input  wire logic         full,
  input  wire logic         kind_i,
  input  wire logic [3:0]   nybble_i,
  input  wire logic [3:0]   dyn_f_i,
  input  wire logic         init_black_i,
  input  wire logic         empty,
  input  wire logic         pop,
  input  wire logic [1:0]   result_kind_i,
  input  wire logic [31:0]  value_i,
  input  wire logic         black_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                runs_o,
  output int                repeats_o,
  output int                errors_o
);

  phase_e      cur_phase;
  logic [2:0]  zeros_seen;
  logic [3:0]  digits_togo;
  logic [31:0] acc;
  logic [3:0]  lead;
  logic        in_rpt;
  logic        colour;
  logic [3:0]  dyn;

  res_t        pending_q[$];

  task automatic clear_number();
    cur_phase   = PH_IDLE;
    zeros_seen  = '0;
    digits_togo = '0;
    acc         = '0;
    lead        = '0;
    in_rpt      = 1'b0;
  endtask

  task automatic emit_count(input logic [63:0] cnt);
    res_t r;
    r.value = (cnt > 64'hffff_ffff) ? '1 : cnt[31:0];
    if (in_rpt) begin
      r.kind  = RK_REPEAT;
      r.black = 1'b0;
    end else begin
      r.kind  = RK_RUN;
      r.black = colour;
      colour  = ~colour;
    end
    pending_q = {pending_q, r};
    clear_number();
  endtask

  task automatic emit_error();
    res_t r;
    r.kind  = RK_ERROR;
    r.value = '0;
    r.black = 1'b0;
    pending_q = {pending_q, r};
    clear_number();
  endtask

  task automatic decode_word(input logic k, input logic [3:0] n, input logic [3:0] f,
                             input logic fb);
    logic [63:0] cnt;
    if (k == KIND_START) begin
      clear_number();
      dyn    = (f > DYN_F_MAX) ? DYN_F_MAX : f;
      colour = fb;
    end else begin
      case (cur_phase)
        PH_SECOND: begin
          cnt = ({60'd0, lead} - {60'd0, dyn} - 64'd1) * 64'd16 + {60'd0, n}
                + {60'd0, dyn} + 64'd1;
          emit_count(cnt);
        end
        PH_ZEROS: begin
          if (n == 4'd0) begin
            if (zeros_seen >= MAX_PREFIX) emit_error();
            else zeros_seen = zeros_seen + 3'd1;
          end else begin
            acc         = {28'd0, n};
            digits_togo = {1'b0, zeros_seen};
            cur_phase   = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          acc = {acc[27:0], n};
          if (digits_togo != 4'd0) digits_togo = digits_togo - 4'd1;
          if (digits_togo == 4'd0) begin
            cnt = {32'd0, acc} + ({60'd0, DYN_F_MAX} - {60'd0, dyn}) * 64'd16
                  + {60'd0, dyn} - 64'd15;
            emit_count(cnt);
          end
        end
        default: begin
          if (n == 4'd0) begin
            cur_phase  = PH_ZEROS;
            zeros_seen = 3'd1;
          end else if (n <= dyn) begin
            emit_count({60'd0, n});
          end else if (n < CODE_REPEAT) begin
            lead      = n;
            cur_phase = PH_SECOND;
          end else if (in_rpt) begin
            emit_error();
          end else if (n == CODE_REPEAT) begin
            in_rpt = 1'b1;
          end else begin
            in_rpt = 1'b1;
            emit_count(64'd1);
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clear_number();
      colour       = 1'b0;
      dyn          = '0;
      pending_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      runs_o       = 0;
      repeats_o    = 0;
      errors_o     = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result word: kind %0d value %0h black %0b",
                 result_kind_i, value_i, black_i);
          fail_count_o++;
        end else begin
          want = pending_q.pop_front();
          case (want.kind)
            RK_RUN:    runs_o++;
            RK_REPEAT: repeats_o++;
            default:   errors_o++;
          endcase
          if (result_kind_i !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind_i);
            fail_count_o++;
          end
          if (value_i !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, value_i);
            fail_count_o++;
          end
          if (black_i !== want.black) begin
            $error("black: expected %0b, got %0b", want.black, black_i);
            fail_count_o++;
          end
        end
      end
      if (push && !full) decode_word(kind_i, nybble_i, dyn_f_i, init_black_i);
      pending_o = pending_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: stimulus and verdict for pk_packed_number_decoder_core
// depends on pnd_pkg, the core and pnd_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_top
  import pnd_pkg::*;
;

  localparam int MAX_PREFIX  = 7;
  localparam int WORD_TARGET = 1375;
  localparam int CALM_POINT  = 1200;
  localparam int HOLD_POINT  = 400;
  localparam int PAUSE_POINT = 800;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        pop;
  logic        kind;
  logic [3:0]  nybble;
  logic [3:0]  dyn_f;
  logic        init_black;
  wire         full;
  wire         empty;
  wire [1:0]   result_kind;
  wire [31:0]  value;
  wire         black;

  int          fail_count;
  int          pending;
  int          runs_seen;
  int          repeats_seen;
  int          errors_seen;
  int          words_sent;
  int          glyph_dyn;
  int          cycle_count;
  int          pick;
  bit          idle_on;
  bit          hold_req;
  bit          hold_done;
  bit          pause_done;

  pk_packed_number_decoder_core #(
    .MAX_PREFIX(MAX_PREFIX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind),
    .nybble_i      (nybble),
    .dyn_f_i       (dyn_f),
    .init_black_i  (init_black),
    .empty         (empty),
    .pop           (pop),
    .result_kind_o (result_kind),
    .value_o       (value),
    .black_o       (black)
  );

  pnd_checker #(
    .MAX_PREFIX(MAX_PREFIX)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind),
    .nybble_i      (nybble),
    .dyn_f_i       (dyn_f),
    .init_black_i  (init_black),
    .empty         (empty),
    .pop           (pop),
    .result_kind_i (result_kind),
    .value_i       (value),
    .black_i       (black),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .runs_o        (runs_seen),
    .repeats_o     (repeats_seen),
    .errors_o      (errors_seen)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    bit hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 1'b0;
    pop        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic put_word(input logic k, input logic [3:0] n, input logic [3:0] f,
                          input logic fb);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    push        <= 1'b1;
    kind        <= k;
    nybble      <= n;
    dyn_f       <= f;
    init_black  <= fb;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic put_nybble(input logic [3:0] n);
    put_word(KIND_NYBBLE, n, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic put_start(input logic [3:0] f, input logic fb);
    glyph_dyn = (f > DYN_F_MAX) ? DYN_F_MAX : f;
    put_word(KIND_START, 4'($urandom_range(0, 15)), f, fb);
  endtask

  // one well-formed packed number for the current dyn_f
  task automatic put_number();
    int form;
    int zp;
    form = $urandom_range(0, 9);
    if (form < 4 && glyph_dyn != 0) begin
      put_nybble(4'($urandom_range(1, glyph_dyn)));
    end else if (form < 7 && glyph_dyn < DYN_F_MAX) begin
      put_nybble(4'($urandom_range(glyph_dyn + 1, DYN_F_MAX)));
      put_nybble(4'($urandom_range(0, 15)));
    end else begin
      zp = ($urandom_range(0, 7) == 0) ? MAX_PREFIX : $urandom_range(1, 3);
      repeat (zp) put_nybble(4'd0);
      put_nybble(4'($urandom_range(1, 15)));
      repeat (zp) put_nybble(4'($urandom_range(0, 15)));
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    kind        = KIND_START;
    nybble      = '0;
    dyn_f       = '0;
    init_black  = 1'b0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    words_sent  = 0;
    glyph_dyn   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // no start yet: longest count with dyn_f zero saturates
    repeat (MAX_PREFIX) put_nybble(4'd0);
    repeat (MAX_PREFIX + 1) put_nybble(4'hf);
    // repeat inside a repeat, then a plain repeat of one row
    put_nybble(CODE_REPEAT);
    put_nybble(CODE_REPEAT_ONE);
    put_nybble(CODE_REPEAT_ONE);
    // one zero prefix too many
    repeat (MAX_PREFIX + 1) put_nybble(4'd0);
    // dyn_f above the limit is clamped
    put_start(4'hf, 1'b1);
    put_nybble(DYN_F_MAX);

    while (words_sent < WORD_TARGET) begin
      if (words_sent > CALM_POINT) idle_on = 1'b0;
      if (!hold_done && words_sent > HOLD_POINT) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        put_start(DYN_F_MAX, 1'($urandom_range(0, 1)));
        repeat (12) put_nybble(4'($urandom_range(1, DYN_F_MAX)));
      end
      if (!pause_done && words_sent > PAUSE_POINT) begin
        pause_done = 1'b1;
        drain_results();
        repeat ($urandom_range(3, 10)) @(negedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        put_start(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else if (pick < 11) begin
        repeat ($urandom_range(1, 4)) put_nybble(4'($urandom_range(0, 15)));
      end else if (pick < 13) begin
        repeat (MAX_PREFIX + 1) put_nybble(4'd0);
      end else if (pick < 17) begin
        put_nybble(CODE_REPEAT_ONE);
      end else if (pick < 25) begin
        put_nybble(CODE_REPEAT);
        put_number();
      end else begin
        put_number();
      end
    end

    drain_results();
    repeat (20) @(negedge clk_i);

    $display("sent %0d input words over varied dyn_f, colours, stalls and a full queue",
             words_sent);
    $display("checked %0d runs, %0d repeats and %0d format errors",
             runs_seen, repeats_seen, errors_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
